[hdl/rmc_pkg.sv]
// ============================================================================
// rmc_pkg: shared types and constants for the RMC sentence parser
// Character codes, capture positions, fixed-point conversion constants and
// the line summary handed from the byte scanner to the conversion pipeline.
// ============================================================================
package rmc_pkg;

    // Longest stored line; bytes at this position and beyond are dropped.
    localparam int LINE_MAX = 80;
    localparam int POS_W    = 7;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_MAX);

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    // Checksum digit counter: two digits taken, or a bad digit seen.
    localparam logic [1:0] HEX_DONE = 2'd2;
    localparam logic [1:0] HEX_BAD  = 2'd3;

    // Comma counter: the byte after the second comma is the fix flag.
    localparam logic [1:0] COMMA_FIX  = 2'd2;
    localparam logic [1:0] COMMA_DONE = 2'd3;

    // Bits of the field stop mask
    localparam int STOP_LAT_DEG = 0;
    localparam int STOP_LAT_MIN = 1;
    localparam int STOP_LON_DEG = 2;
    localparam int STOP_LON_MIN = 3;
    localparam int STOP_SPEED   = 4;

    // Conversion constants
    localparam logic [19:0] MICRO_PER_DEG = 20'd1000000;
    localparam logic [10:0] MPH_INT       = 11'd1150;   // 1.150779 = 1150.779 / 1000
    localparam logic [9:0]  MPH_FRAC      = 10'd779;

    // Reciprocal for x / 3, exact for x below 2**23.
    localparam logic [23:0] RECIP_3       = 24'hAAAAAB;
    localparam int          SHIFT_3       = 25;
    // Reciprocal for x / 1000, exact for x below 2**23.
    localparam logic [23:0] RECIP_K       = 24'd8589935;
    localparam int          SHIFT_K       = 33;
    // Reciprocals for x / 10**f, exact for x below 2**24.
    localparam logic [30:0] RECIP_10      = 31'd1717986919;
    localparam logic [30:0] RECIP_100     = 31'd171798692;
    localparam logic [30:0] RECIP_1000    = 31'd17179870;
    localparam int          SHIFT_DEC     = 34;

    // Everything the conversion needs from one finished line.
    typedef struct packed {
        logic        checksum_ok;
        logic        fix_valid;
        logic [6:0]  lat_deg;
        logic [19:0] lat_min;
        logic        south;
        logic [9:0]  lon_deg;
        logic [19:0] lon_min;
        logic        west;
        logic [13:0] sp_digits;
        logic [1:0]  sp_frac;
    } t_line_snap;

endpackage

[hdl/rmc_if.sv]
// ============================================================================
// rmc_if: request channels of the RMC sentence parser
// rmc_byte_if carries one received character, rmc_res_if one parsed line.
// ============================================================================
interface rmc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rmc_res_if;
    logic               valid;
    logic               ready;
    logic               checksum_ok;
    logic               fix_valid;
    logic signed [27:0] latitude_microdeg;
    logic signed [30:0] longitude_microdeg;
    logic [23:0]        speed_milli_mph;

    modport source (output valid, output checksum_ok, output fix_valid,
                    output latitude_microdeg, output longitude_microdeg,
                    output speed_milli_mph, input ready);
    modport sink   (input valid, input checksum_ok, input fix_valid,
                    input latitude_microdeg, input longitude_microdeg,
                    input speed_milli_mph, output ready);
endinterface

[hdl/rmc_scan.sv]
// ============================================================================
// rmc_scan: per-character line scanner
// Keeps the running checksum, comma count and digit accumulators of the
// current line and hands a summary of the line on at each newline.
// ============================================================================
module rmc_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rmc_byte_if.sink            i_rx,
    output logic                o_snap_valid,
    output rmc_pkg::t_line_snap o_snap,
    input  logic                i_snap_ready
);
    import rmc_pkg::*;

    logic [POS_W-1:0] r_pos,      n_pos;
    logic [7:0]       r_xor,      n_xor;
    logic             r_star,     n_star;
    logic [1:0]       r_hex,      n_hex;
    logic [7:0]       r_sent,     n_sent;
    logic [1:0]       r_commas,   n_commas;
    logic             r_fix,      n_fix;
    logic [6:0]       r_lat_deg,  n_lat_deg;
    logic [19:0]      r_lat_min,  n_lat_min;
    logic [9:0]       r_lon_deg,  n_lon_deg;
    logic [19:0]      r_lon_min,  n_lon_min;
    logic             r_south,    n_south;
    logic             r_west,     n_west;
    logic [13:0]      r_sp,       n_sp;
    logic [1:0]       r_sp_frac,  n_sp_frac;
    logic             r_sp_point, n_sp_point;
    logic [4:0]       r_stop,     n_stop;

    logic       w_acc;
    logic [7:0] w_b;
    logic       w_digit;
    logic       w_hex_letter;
    logic [3:0] w_dval;
    logic [3:0] w_hval;
    logic       w_at_lat_deg, w_at_lat_min, w_at_lon_deg, w_at_lon_min, w_at_speed;

    function automatic logic [19:0] dec_step(input logic [19:0] acc, input logic [3:0] d);
        return 20'(acc * 20'd10 + 20'(d));
    endfunction

    assign w_b          = i_rx.rx_byte;
    assign i_rx.ready   = i_snap_ready;
    assign w_acc        = i_rx.valid && i_rx.ready;
    assign w_digit      = (w_b >= CH_0) && (w_b <= CH_9);
    assign w_hex_letter = (w_b >= CH_A) && (w_b <= CH_F);
    assign w_dval       = w_b[3:0];
    assign w_hval       = w_digit ? w_b[3:0] : 4'(w_b[3:0] + 4'd9);

    assign w_at_lat_deg = (r_pos == 7'd20) || (r_pos == 7'd21);
    assign w_at_lat_min = (r_pos == 7'd22) || (r_pos == 7'd23) ||
                          ((r_pos >= 7'd25) && (r_pos <= 7'd28));
    assign w_at_lon_deg = (r_pos >= 7'd32) && (r_pos <= 7'd34);
    assign w_at_lon_min = (r_pos == 7'd35) || (r_pos == 7'd36) ||
                          ((r_pos >= 7'd38) && (r_pos <= 7'd41));
    assign w_at_speed   = (r_pos >= 7'd45) && (r_pos <= 7'd48);

    // The newline itself is the request that carries the line summary.
    assign o_snap_valid        = i_rx.valid && (w_b == CH_LF);
    assign o_snap.checksum_ok  = r_star && (r_hex == HEX_DONE) && (r_xor == r_sent);
    assign o_snap.fix_valid    = r_fix;
    assign o_snap.lat_deg      = r_lat_deg;
    assign o_snap.lat_min      = r_lat_min;
    assign o_snap.south        = r_south;
    assign o_snap.lon_deg      = r_lon_deg;
    assign o_snap.lon_min      = r_lon_min;
    assign o_snap.west         = r_west;
    assign o_snap.sp_digits    = r_sp;
    assign o_snap.sp_frac      = r_sp_frac;

    always_comb begin
        n_pos      = r_pos;
        n_xor      = r_xor;
        n_star     = r_star;
        n_hex      = r_hex;
        n_sent     = r_sent;
        n_commas   = r_commas;
        n_fix      = r_fix;
        n_lat_deg  = r_lat_deg;
        n_lat_min  = r_lat_min;
        n_lon_deg  = r_lon_deg;
        n_lon_min  = r_lon_min;
        n_south    = r_south;
        n_west     = r_west;
        n_sp       = r_sp;
        n_sp_frac  = r_sp_frac;
        n_sp_point = r_sp_point;
        n_stop     = r_stop;
        if (w_acc && (w_b != CH_CR)) begin
            if (w_b == CH_LF) begin
                n_pos      = '0;
                n_xor      = '0;
                n_star     = 1'b0;
                n_hex      = '0;
                n_sent     = '0;
                n_commas   = '0;
                n_fix      = 1'b0;
                n_lat_deg  = '0;
                n_lat_min  = '0;
                n_lon_deg  = '0;
                n_lon_min  = '0;
                n_south    = 1'b0;
                n_west     = 1'b0;
                n_sp       = '0;
                n_sp_frac  = '0;
                n_sp_point = 1'b0;
                n_stop     = '0;
            end else if (r_pos < POS_LIMIT) begin
                n_pos = POS_W'(r_pos + 1'b1);

                // The leading '$' is neither summed nor taken as the star.
                if (!r_star) begin
                    if (r_pos != '0) begin
                        if (w_b == CH_STAR) begin
                            n_star = 1'b1;
                        end else begin
                            n_xor = r_xor ^ w_b;
                        end
                    end
                end else if (r_hex < HEX_DONE) begin
                    if (w_digit || w_hex_letter) begin
                        n_sent = {r_sent[3:0], w_hval};
                        n_hex  = 2'(r_hex + 1'b1);
                    end else begin
                        n_hex = HEX_BAD;
                    end
                end

                if (r_commas == COMMA_FIX) begin
                    n_fix    = (w_b == CH_A);
                    n_commas = COMMA_DONE;
                end else if ((r_commas < COMMA_FIX) && (w_b == CH_COMMA)) begin
                    n_commas = 2'(r_commas + 1'b1);
                end

                if (w_at_lat_deg && !r_stop[STOP_LAT_DEG]) begin
                    if (w_digit) begin
                        n_lat_deg = 7'(dec_step(20'(r_lat_deg), w_dval));
                    end else begin
                        n_stop[STOP_LAT_DEG] = 1'b1;
                    end
                end
                if (w_at_lat_min && !r_stop[STOP_LAT_MIN]) begin
                    if (w_digit) begin
                        n_lat_min = dec_step(r_lat_min, w_dval);
                    end else begin
                        n_stop[STOP_LAT_MIN] = 1'b1;
                    end
                end
                if (r_pos == 7'd30) begin
                    n_south = (w_b == CH_S);
                end
                if (w_at_lon_deg && !r_stop[STOP_LON_DEG]) begin
                    if (w_digit) begin
                        n_lon_deg = 10'(dec_step(20'(r_lon_deg), w_dval));
                    end else begin
                        n_stop[STOP_LON_DEG] = 1'b1;
                    end
                end
                if (w_at_lon_min && !r_stop[STOP_LON_MIN]) begin
                    if (w_digit) begin
                        n_lon_min = dec_step(r_lon_min, w_dval);
                    end else begin
                        n_stop[STOP_LON_MIN] = 1'b1;
                    end
                end
                if (r_pos == 7'd43) begin
                    n_west = (w_b == CH_W);
                end
                // Speed takes one decimal point and counts the digits after it.
                if (w_at_speed && !r_stop[STOP_SPEED]) begin
                    if (w_digit) begin
                        n_sp = 14'(dec_step(20'(r_sp), w_dval));
                        if (r_sp_point) begin
                            n_sp_frac = 2'(r_sp_frac + 1'b1);
                        end
                    end else if ((w_b == CH_DOT) && !r_sp_point) begin
                        n_sp_point = 1'b1;
                    end else begin
                        n_stop[STOP_SPEED] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_xor      <= '0;
            r_star     <= 1'b0;
            r_hex      <= '0;
            r_sent     <= '0;
            r_commas   <= '0;
            r_fix      <= 1'b0;
            r_lat_deg  <= '0;
            r_lat_min  <= '0;
            r_lon_deg  <= '0;
            r_lon_min  <= '0;
            r_south    <= 1'b0;
            r_west     <= 1'b0;
            r_sp       <= '0;
            r_sp_frac  <= '0;
            r_sp_point <= 1'b0;
            r_stop     <= '0;
        end else begin
            r_pos      <= n_pos;
            r_xor      <= n_xor;
            r_star     <= n_star;
            r_hex      <= n_hex;
            r_sent     <= n_sent;
            r_commas   <= n_commas;
            r_fix      <= n_fix;
            r_lat_deg  <= n_lat_deg;
            r_lat_min  <= n_lat_min;
            r_lon_deg  <= n_lon_deg;
            r_lon_min  <= n_lon_min;
            r_south    <= n_south;
            r_west     <= n_west;
            r_sp       <= n_sp;
            r_sp_frac  <= n_sp_frac;
            r_sp_point <= n_sp_point;
            r_stop     <= n_stop;
        end
    end

`ifndef SYNTHESIS
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LIMIT)
        else $error("line position ran past the line limit");

    a_lf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_b == CH_LF)) |=> ((r_pos == '0) && (r_xor == '0) && !r_star &&
                                       (r_stop == '0) && (r_commas == '0)))
        else $error("line state not cleared after newline");

    a_cr_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_b == CH_CR)) |=> $stable(r_pos) && $stable(r_xor))
        else $error("carriage return changed the line state");

    a_frac_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sp_frac != '0) |-> r_sp_point)
        else $error("speed fraction digits counted without a decimal point");
`endif

endmodule

[hdl/rmc_conv.sv]
// ============================================================================
// rmc_conv: fixed-point conversion pipeline
// Turns a line summary into micro-degrees and thousandths of mph over four
// register stages plus the result register, with per-stage flow control.
// ============================================================================
module rmc_conv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_snap_valid,
    input  rmc_pkg::t_line_snap i_snap,
    output logic                o_snap_ready,
    rmc_res_if.source           o_res
);
    import rmc_pkg::*;

    // Stage valids and advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic w_en1, w_en2, w_en3, w_en4, w_eno;

    // Stage 1: captured summary
    t_line_snap r1;

    // Stage 2: first products
    logic [26:0] r2_lat_dp;
    logic [22:0] r2_lat_m5;
    logic [29:0] r2_lon_dp;
    logic [22:0] r2_lon_m5;
    logic [23:0] r2_sp_a;
    logic [22:0] r2_sp_b;
    logic        r2_ok, r2_fix, r2_south, r2_west;
    logic [1:0]  r2_frac;

    // Stage 3: divisions by constants
    logic [26:0] r3_lat_dp;
    logic [20:0] r3_lat_q;
    logic [29:0] r3_lon_dp;
    logic [20:0] r3_lon_q;
    logic [23:0] r3_sp_a;
    logic [12:0] r3_sp_q;
    logic        r3_ok, r3_fix, r3_south, r3_west;
    logic [1:0]  r3_frac;

    // Stage 4: magnitudes
    logic [26:0] r4_lat_mag;
    logic [29:0] r4_lon_mag;
    logic [23:0] r4_sp_q1;
    logic        r4_ok, r4_fix, r4_south, r4_west;
    logic [1:0]  r4_frac;

    // Result register
    logic               r_ok, r_fix;
    logic signed [27:0] r_lat;
    logic signed [30:0] r_lon;
    logic [23:0]        r_sp;

    logic [46:0] w_lat_qp, w_lon_qp, w_sp_qp;
    logic [30:0] w_recip;
    logic [54:0] w_sp_prod;
    logic [23:0] w_sp_out;
    logic [27:0] w_lat_ext;
    logic [30:0] w_lon_ext;

    assign w_eno        = !r_vo || o_res.ready;
    assign w_en4        = !r_v4 || w_eno;
    assign w_en3        = !r_v3 || w_en4;
    assign w_en2        = !r_v2 || w_en3;
    assign w_en1        = !r_v1 || w_en2;
    assign o_snap_ready = w_en1;

    assign w_lat_qp = 47'(r2_lat_m5) * 47'(RECIP_3);
    assign w_lon_qp = 47'(r2_lon_m5) * 47'(RECIP_3);
    assign w_sp_qp  = 47'(r2_sp_b) * 47'(RECIP_K);

    always_comb begin
        unique case (r4_frac)
            2'd0:    w_recip = '0;
            2'd1:    w_recip = RECIP_10;
            2'd2:    w_recip = RECIP_100;
            default: w_recip = RECIP_1000;
        endcase
    end

    assign w_sp_prod = 55'(r4_sp_q1) * 55'(w_recip);
    assign w_sp_out  = (r4_frac == 2'd0) ? r4_sp_q1
                                         : 24'(w_sp_prod[SHIFT_DEC+20:SHIFT_DEC]);
    assign w_lat_ext = {1'b0, r4_lat_mag};
    assign w_lon_ext = {1'b0, r4_lon_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_snap_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
            if (w_eno) begin
                r_vo <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1 <= i_snap;
        end
        if (w_en2) begin
            r2_lat_dp <= 27'(r1.lat_deg) * 27'(MICRO_PER_DEG);
            r2_lat_m5 <= 23'({r1.lat_min, 2'b00}) + 23'(r1.lat_min);
            r2_lon_dp <= 30'(r1.lon_deg) * 30'(MICRO_PER_DEG);
            r2_lon_m5 <= 23'({r1.lon_min, 2'b00}) + 23'(r1.lon_min);
            r2_sp_a   <= 24'(r1.sp_digits) * 24'(MPH_INT);
            r2_sp_b   <= 23'(r1.sp_digits) * 23'(MPH_FRAC);
            r2_ok     <= r1.checksum_ok;
            r2_fix    <= r1.fix_valid;
            r2_south  <= r1.south;
            r2_west   <= r1.west;
            r2_frac   <= r1.sp_frac;
        end
        if (w_en3) begin
            r3_lat_dp <= r2_lat_dp;
            r3_lat_q  <= w_lat_qp[SHIFT_3+20:SHIFT_3];
            r3_lon_dp <= r2_lon_dp;
            r3_lon_q  <= w_lon_qp[SHIFT_3+20:SHIFT_3];
            r3_sp_a   <= r2_sp_a;
            r3_sp_q   <= w_sp_qp[SHIFT_K+12:SHIFT_K];
            r3_ok     <= r2_ok;
            r3_fix    <= r2_fix;
            r3_south  <= r2_south;
            r3_west   <= r2_west;
            r3_frac   <= r2_frac;
        end
        if (w_en4) begin
            r4_lat_mag <= r3_lat_dp + 27'(r3_lat_q);
            r4_lon_mag <= r3_lon_dp + 30'(r3_lon_q);
            r4_sp_q1   <= r3_sp_a + 24'(r3_sp_q);
            r4_ok      <= r3_ok;
            r4_fix     <= r3_fix;
            r4_south   <= r3_south;
            r4_west    <= r3_west;
            r4_frac    <= r3_frac;
        end
        if (w_eno) begin
            r_ok  <= r4_ok;
            r_fix <= r4_fix;
            r_lat <= $signed(r4_south ? 28'(28'd0 - w_lat_ext) : w_lat_ext);
            r_lon <= $signed(r4_west ? 31'(31'd0 - w_lon_ext) : w_lon_ext);
            r_sp  <= w_sp_out;
        end
    end

    assign o_res.valid              = r_vo;
    assign o_res.checksum_ok        = r_ok;
    assign o_res.fix_valid          = r_fix;
    assign o_res.latitude_microdeg  = r_lat;
    assign o_res.longitude_microdeg = r_lon;
    assign o_res.speed_milli_mph    = r_sp;

endmodule

[hdl/nmea_rmc_line_parser_top.sv]
// ============================================================================
// nmea_rmc_line_parser_top: RMC sentence parser
// Parses a stream of received characters into checksum status, fix flag,
// position in micro-degrees and ground speed in thousandths of mph.
// ============================================================================
// The parser takes one character per clock on i_rx while i_rx.ready is high,
// with no gaps needed between lines. Carriage returns are skipped, and each
// newline produces exactly one result on o_res; the scanner updates its
// running line state in the cycle a character arrives, and the newline's
// summary then passes through a five-register conversion pipeline
// (capture, products, divisions by constants, sums, sign). i_rx.ready falls
// only when the pipeline is full and o_res is held off, so up to five
// finished lines can be in flight at once.
module nmea_rmc_line_parser_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmc_byte_if.sink  i_rx,
    rmc_res_if.source o_res
);
    import rmc_pkg::*;

    logic       w_snap_valid;
    logic       w_snap_ready;
    t_line_snap w_snap;

    rmc_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .o_snap_valid (w_snap_valid),
        .o_snap       (w_snap),
        .i_snap_ready (w_snap_ready)
    );

    rmc_conv u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (w_snap_valid),
        .i_snap       (w_snap),
        .o_snap_ready (w_snap_ready),
        .o_res        (o_res)
    );

endmodule
